>>> rtl/kmm_pkg.sv
// shared types and codes for the k-way merge block
`timescale 1ns / 1ps

package kmm_pkg;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;
    localparam int OUT_W     = 32;
    localparam int SRC_W     = 2;
    localparam int LIDX_W    = 2;
    localparam int CFG_W     = 3;
    localparam logic [CFG_W-1:0] LISTS_RESET = 3'd4;

    typedef enum logic [1:0] {
        ST_PUSHED  = 2'd0,
        ST_POPPED  = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_DROPPED = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_PUSH,
        FSM_SCAN,
        FSM_LAST,
        FSM_POP,
        FSM_RESP
    } fsm_t;

    typedef struct packed {
        status_t            status;
        logic [OUT_W-1:0]   value;
        logic [SRC_W-1:0]   source;
    } result_t;

endpackage

>>> rtl/kmm_store.sv
// entry memory: one write port, one read port with registered read data
`timescale 1ns / 1ps

module kmm_store #(
    parameter int ADDR_W     = 6,
    parameter int DATA_WIDTH = 32
) (
    input  logic                  aclk,
    input  logic                  wr_en,
    input  logic [ADDR_W-1:0]     wr_addr,
    input  logic [DATA_WIDTH-1:0] wr_data,
    input  logic                  rd_en,
    input  logic [ADDR_W-1:0]     rd_addr,
    output logic [DATA_WIDTH-1:0] rd_data
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_WIDTH-1:0] mem [0:DEPTH-1];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/kmm_ctrl.sv
// list pointers, head scan and push/pop sequencing around the entry memory
`timescale 1ns / 1ps

module kmm_ctrl #(
    parameter int NUM_LISTS  = 4,
    parameter int LIST_DEPTH = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        in_kind,
    input  logic [kmm_pkg::LIDX_W-1:0]  in_list,
    input  logic [kmm_pkg::OUT_W-1:0]   in_value,
    input  logic [kmm_pkg::CFG_W-1:0]   lists_in_use,
    output logic                        res_valid,
    input  logic                        res_ready,
    output kmm_pkg::result_t            res
);

    import kmm_pkg::*;

    localparam int IDX_W  = $clog2(NUM_LISTS);
    localparam int PTR_W  = $clog2(LIST_DEPTH);
    localparam int FILL_W = $clog2(LIST_DEPTH + 1);
    localparam int ADDR_W = IDX_W + PTR_W;
    localparam int CMP_W  = IDX_W + CFG_W;
    localparam int EXT_W  = (DATA_WIDTH > OUT_W) ? DATA_WIDTH : OUT_W;

    fsm_t state_reg, state_next;

    logic [PTR_W-1:0]  rptr_reg [0:NUM_LISTS-1];
    logic [PTR_W-1:0]  wptr_reg [0:NUM_LISTS-1];
    logic [FILL_W-1:0] fill_reg [0:NUM_LISTS-1];

    logic [LIDX_W-1:0]     idx_reg;
    logic [DATA_WIDTH-1:0] value_reg;
    logic [IDX_W-1:0]      scan_cnt_reg;
    logic                  pend_vld_reg;
    logic [IDX_W-1:0]      pend_idx_reg;
    logic                  found_reg;
    logic [IDX_W-1:0]      best_reg;
    logic [DATA_WIDTH-1:0] best_val_reg;
    result_t               res_reg;

    logic [IDX_W-1:0]      sel;
    logic [PTR_W-1:0]      rptr_sel;
    logic [PTR_W-1:0]      wptr_sel;
    logic [FILL_W-1:0]     fill_sel;
    logic                  push_ok;
    logic                  scan_active;
    logic                  take;
    logic                  wr_en;
    logic                  rd_en;
    logic [DATA_WIDTH-1:0] rd_data;
    logic signed [EXT_W-1:0] best_ext;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        bump = (p == PTR_W'(LIST_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // one list is looked at per cycle, chosen by the current phase
    always_comb begin
        unique case (state_reg)
            FSM_SCAN: sel = scan_cnt_reg;
            FSM_POP:  sel = best_reg;
            default:  sel = IDX_W'(idx_reg);
        endcase
    end

    assign rptr_sel    = rptr_reg[sel];
    assign wptr_sel    = wptr_reg[sel];
    assign fill_sel    = fill_reg[sel];
    assign push_ok     = (32'(idx_reg) < NUM_LISTS) && (fill_sel != FILL_W'(LIST_DEPTH));
    assign scan_active = (CMP_W'(scan_cnt_reg) < CMP_W'(lists_in_use)) && (fill_sel != '0);
    // strict less keeps the lowest list on equal heads
    assign take        = pend_vld_reg &&
                         (!found_reg || ($signed(rd_data) < $signed(best_val_reg)));
    assign best_ext    = EXT_W'($signed(best_val_reg));

    kmm_store #(
        .ADDR_W     (ADDR_W),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr ({sel, wptr_sel}),
        .wr_data (value_reg),
        .rd_en   (rd_en),
        .rd_addr ({sel, rptr_sel}),
        .rd_data (rd_data)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            FSM_IDLE: begin
                if (in_valid) begin
                    state_next = in_kind ? FSM_SCAN : FSM_PUSH;
                end
            end
            FSM_PUSH: state_next = FSM_RESP;
            FSM_SCAN: begin
                if (scan_cnt_reg == IDX_W'(NUM_LISTS - 1)) begin
                    state_next = FSM_LAST;
                end
            end
            FSM_LAST: state_next = FSM_POP;
            FSM_POP:  state_next = FSM_RESP;
            FSM_RESP: begin
                if (res_ready) begin
                    state_next = FSM_IDLE;
                end
            end
            default:  state_next = FSM_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        in_ready  = (state_reg == FSM_IDLE);
        wr_en     = (state_reg == FSM_PUSH) && push_ok;
        rd_en     = (state_reg == FSM_SCAN);
        res_valid = (state_reg == FSM_RESP);
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= FSM_IDLE;
            pend_vld_reg <= 1'b0;
            found_reg    <= 1'b0;
            scan_cnt_reg <= '0;
            for (int i = 0; i < NUM_LISTS; i++) begin
                rptr_reg[i] <= '0;
                wptr_reg[i] <= '0;
                fill_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            unique case (state_reg)
                FSM_IDLE: begin
                    scan_cnt_reg <= '0;
                    pend_vld_reg <= 1'b0;
                    found_reg    <= 1'b0;
                end
                FSM_PUSH: begin
                    if (push_ok) begin
                        wptr_reg[sel] <= bump(wptr_sel);
                        fill_reg[sel] <= fill_sel + 1'b1;
                    end
                end
                FSM_SCAN: begin
                    scan_cnt_reg <= scan_cnt_reg + 1'b1;
                    pend_vld_reg <= scan_active;
                    if (take) begin
                        found_reg <= 1'b1;
                    end
                end
                FSM_LAST: begin
                    pend_vld_reg <= 1'b0;
                    if (take) begin
                        found_reg <= 1'b1;
                    end
                end
                FSM_POP: begin
                    if (found_reg) begin
                        rptr_reg[sel] <= bump(rptr_sel);
                        fill_reg[sel] <= fill_sel - 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            FSM_IDLE: begin
                if (in_valid) begin
                    idx_reg   <= in_list;
                    value_reg <= DATA_WIDTH'(in_value);
                end
            end
            FSM_PUSH: begin
                res_reg.status <= push_ok ? ST_PUSHED : ST_DROPPED;
                res_reg.value  <= '0;
                res_reg.source <= '0;
            end
            FSM_SCAN, FSM_LAST: begin
                if (state_reg == FSM_SCAN) begin
                    pend_idx_reg <= scan_cnt_reg;
                end
                if (take) begin
                    best_reg     <= pend_idx_reg;
                    best_val_reg <= rd_data;
                end
            end
            FSM_POP: begin
                if (found_reg) begin
                    res_reg.status <= ST_POPPED;
                    res_reg.value  <= best_ext[OUT_W-1:0];
                    res_reg.source <= SRC_W'(best_reg);
                end else begin
                    res_reg.status <= ST_EMPTY;
                    res_reg.value  <= '0;
                    res_reg.source <= '0;
                end
            end
            default: begin
            end
        endcase
    end

    assign res = res_reg;

endmodule

>>> rtl/kway_merge_min_head.sv
// top level: stream ports, list-count register and output register of the k-way merge
// push: the request goes through the PUSH and RESP states, then into the output register
// pop: SCAN over every list, then LAST, POP and RESP; a new request is taken only in IDLE
// a pop reads the list heads through the single memory read port, one list head read per cycle
// the output register lets the next request in while a result waits on m_tready
// reset: aresetn synchronous active low, lists empty, lists_in_use back to 4
// entry memory is not cleared; only counted entries are ever read
`timescale 1ns / 1ps

module kway_merge_min_head #(
    parameter int NUM_LISTS  = 4,
    parameter int LIST_DEPTH = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // request stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [kmm_pkg::S_TDATA_W-1:0]   s_tdata,  // [1:0] list_index, [33:2] value, rest zero
    input  logic                            s_tuser,  // [0] kind: 0 push, 1 pop
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [kmm_pkg::M_TDATA_W-1:0]   m_tdata,  // [31:0] merged_value, [33:32] source_list
    output logic [1:0]                      m_tuser,  // [1:0] status
    // list-count register write
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [kmm_pkg::CFG_W-1:0]       cfg_data   // lists_in_use
);

    import kmm_pkg::*;

    logic [CFG_W-1:0] lists_reg;
    logic             m_valid_reg;
    result_t          m_res_reg;
    logic             res_valid;
    logic             res_ready;
    result_t          res;

    // the register is to be written only while idle; the block itself does not enforce it, so it is always open
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lists_reg <= LISTS_RESET;
        end else if (cfg_valid) begin
            lists_reg <= cfg_data;
        end
    end

    kmm_ctrl #(
        .NUM_LISTS  (NUM_LISTS),
        .LIST_DEPTH (LIST_DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_kind      (s_tuser),
        .in_list      (s_tdata[LIDX_W-1:0]),
        .in_value     (s_tdata[LIDX_W +: OUT_W]),
        .lists_in_use (lists_reg),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res)
    );

    // output register: refill when empty or being drained
    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_res_reg.status;
    assign m_tdata  = {{(M_TDATA_W - OUT_W - SRC_W){1'b0}}, m_res_reg.source, m_res_reg.value};

endmodule

>>> rtl/kmm_checker.sv
// port-level checks for the k-way merge, bound to the top level
`timescale 1ns / 1ps

module kmm_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [kmm_pkg::S_TDATA_W-1:0] s_tdata,
    input logic                          s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [kmm_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [1:0]                    m_tuser,
    input logic                          cfg_valid,
    input logic                          cfg_ready,
    input logic [kmm_pkg::CFG_W-1:0]     cfg_data
);

    import kmm_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // no result straight out of reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // only a pop carries a value and a source
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != ST_POPPED) |-> (m_tdata == '0))
        else $error("nonzero payload on non-pop result");

    // one request at a time: taking a request closes the input
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

endmodule

bind kway_merge_min_head kmm_checker u_kmm_checker (.*);

>>> sim/tb_top.sv
// self-checking testbench for the k-way merge block: list push/pop requests against a predictor
`timescale 1ns / 1ps

module tb_top;
    import kmm_pkg::*;

    localparam int NUM_LISTS       = 4;
    localparam int LIST_DEPTH      = 16;
    localparam int RESET_CYCLES    = 7;
    // settle time covers a whole pop plus margin for the output register
    localparam int SETTLE_CYCLES   = NUM_LISTS + 8;
    localparam int IDLE_LIMIT      = 3000;
    localparam int ITEMS_PER_PHASE = 42;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } op_t;

    typedef struct {
        op_t               op;
        logic [LIDX_W-1:0] list_idx;
        logic [OUT_W-1:0]  value;
    } request_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [1:0]           m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_W-1:0]     cfg_data  = '0;

    // predictor state: one fifo per list plus the list-count register
    logic signed [OUT_W-1:0] list_fifo [NUM_LISTS][$];
    logic [CFG_W-1:0]        lists_active = LISTS_RESET;

    request_t request_backlog[$];
    result_t  merge_results_due[$];
    request_t in_flight;

    int  gap_left   = 0;
    int  stall_left = 0;
    int  idle_count = 0;
    int  errors     = 0;
    int  n_sent     = 0;
    int  n_pushed   = 0;
    int  n_dropped  = 0;
    int  n_popped   = 0;
    int  n_empty    = 0;
    int  n_settings = 0;
    bit  steady     = 1'b0;

    kway_merge_min_head #(
        .NUM_LISTS  (NUM_LISTS),
        .LIST_DEPTH (LIST_DEPTH),
        .DATA_WIDTH (32)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // [1:0] list_index, [33:2] value, rest zero
        .s_tuser   (s_tuser),   // [0] kind
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // [31:0] merged_value, [33:32] source_list
        .m_tuser   (m_tuser),   // [1:0] status
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // extremes and near-zero values show up often so that ties happen
    function automatic logic [OUT_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 32'h7fff_ffff;
        if (r == 1) return 32'h8000_0000;
        if (r < 4) return 32'($signed($urandom_range(0, 7)) - 4);
        return $urandom;
    endfunction

    // next result of the merge for one request, updating the list model
    function automatic result_t predict_merge(request_t rq);
        result_t res;
        int      act;
        int      best;
        int      i;
        res = '{status: ST_PUSHED, value: '0, source: '0};
        if (rq.op == OP_PUSH) begin
            if (int'(rq.list_idx) >= NUM_LISTS || list_fifo[rq.list_idx].size() >= LIST_DEPTH) begin
                res.status = ST_DROPPED;
                n_dropped++;
            end else begin
                list_fifo[rq.list_idx].push_back(rq.value);
                n_pushed++;
            end
            return res;
        end
        // register values above the list count saturate
        act  = (int'(lists_active) > NUM_LISTS) ? NUM_LISTS : int'(lists_active);
        best = -1;
        // strict less-than keeps the lowest list on equal heads, max value included
        for (i = 0; i < act; i++) begin
            if (list_fifo[i].size() != 0) begin
                if (best < 0 || list_fifo[i][0] < list_fifo[best][0]) best = i;
            end
        end
        if (best < 0) begin
            res.status = ST_EMPTY;
            n_empty++;
        end else begin
            res.status = ST_POPPED;
            res.value  = list_fifo[best].pop_front();
            res.source = SRC_W'(best);
            n_popped++;
        end
        return res;
    endfunction

    // request driver: one request in flight, held until taken
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            gap_left = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                merge_results_due.push_back(predict_merge(in_flight));
                n_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (request_backlog.size() != 0) begin
                    in_flight = request_backlog.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {{(S_TDATA_W-OUT_W-LIDX_W){1'b0}}, in_flight.value,
                                 in_flight.list_idx};
                    s_tuser  <= in_flight.op;
                    gap_left = steady ? 0 : pick_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor with random back-pressure
    always @(posedge aclk) begin
        result_t due;
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (merge_results_due.size() == 0) begin
                    $error("result with nothing expected: status %0d value %0d",
                           m_tuser, $signed(m_tdata[OUT_W-1:0]));
                    errors++;
                end else begin
                    due = merge_results_due.pop_front();
                    if (status_t'(m_tuser) !== due.status) begin
                        $error("status: expected %0d, got %0d", due.status, m_tuser);
                        errors++;
                    end
                    if (m_tdata[OUT_W-1:0] !== due.value) begin
                        $error("merged_value: expected %0d, got %0d",
                               $signed(due.value), $signed(m_tdata[OUT_W-1:0]));
                        errors++;
                    end
                    if (m_tdata[OUT_W+SRC_W-1:OUT_W] !== due.source) begin
                        $error("source_list: expected %0d, got %0d",
                               due.source, m_tdata[OUT_W+SRC_W-1:OUT_W]);
                        errors++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (!steady && $urandom_range(0, 3) == 0) stall_left = pick_gap();
            end
        end
    end

    // watchdog: too long with no handshake on any channel
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic add_request(input op_t op, input int idx, input logic [OUT_W-1:0] v);
        request_t rq;
        rq.op       = op;
        rq.list_idx = LIDX_W'(idx);
        rq.value    = v;
        request_backlog.push_back(rq);
    endtask

    task automatic add_push_burst(input int idx, input int len);
        int k;
        for (k = 0; k < len; k++) add_request(OP_PUSH, idx, pick_value());
    endtask

    // sender holds off until every result is back and the block has gone quiet
    task automatic wait_drained();
        do @(negedge aclk);
        while (request_backlog.size() != 0 || s_tvalid || merge_results_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_lists(input logic [CFG_W-1:0] v);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        lists_active = v;
        n_settings++;
        @(negedge aclk);
    endtask

    // random mix: push bursts that fill lists, pop bursts that drain them, loose requests
    task automatic fill_phase(input int n, input int setting);
        int added;
        int r;
        int len;
        added = 0;
        if (setting == 0) begin
            // nothing pops now, so overfill one list and let later phases drain it
            add_push_burst($urandom_range(0, NUM_LISTS-1), LIST_DEPTH + 2);
            added += LIST_DEPTH + 2;
        end
        while (added < n) begin
            r = $urandom_range(0, 9);
            if (r < 3) begin
                len = $urandom_range(1, 20);
                add_push_burst($urandom_range(0, NUM_LISTS-1), len);
            end else if (r < 5) begin
                len = $urandom_range(1, 12);
                repeat (len) add_request(OP_POP, $urandom_range(0, 3), $urandom);
            end else begin
                len = 1;
                add_request(op_t'($urandom_range(0, 1)), $urandom_range(0, 3), pick_value());
            end
            added += len;
            if ($urandom_range(0, 14) == 0) wait_drained();
        end
    endtask

    initial begin
        int settings[8] = '{1, 0, 7, 2, 5, 3, 6, 4};
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed part, register still at its reset value
        add_request(OP_POP, 0, '0);                  // pop with every list empty
        add_request(OP_PUSH, 3, 32'h7fff_ffff);
        add_request(OP_PUSH, 1, 32'h7fff_ffff);
        add_request(OP_PUSH, 2, 32'h7fff_ffff);
        add_request(OP_POP, 0, '1);                  // all heads at max: lowest list wins
        add_request(OP_PUSH, 0, 32'h8000_0000);
        add_request(OP_PUSH, 2, 32'hffff_ffff);
        add_request(OP_POP, 3, '0);                  // most negative value
        add_request(OP_POP, 0, '0);                  // max tie between lists 2 and 3
        add_request(OP_POP, 0, '0);
        add_request(OP_POP, 0, '0);
        add_request(OP_POP, 0, '0);                  // empty again
        add_request(OP_PUSH, 1, 32'h0000_0000);
        add_request(OP_PUSH, 0, 32'h0000_0000);
        add_request(OP_POP, 0, '0);                  // zero tie
        add_request(OP_POP, 0, '0);
        add_request(OP_PUSH, 3, 32'h5555_5555);
        add_request(OP_PUSH, 3, 32'haaaa_aaaa);
        add_request(OP_POP, 0, '0);
        add_request(OP_POP, 0, '0);
        wait_drained();

        // one phase per list-count setting, zero and the saturating values included
        foreach (settings[p]) begin
            write_lists(CFG_W'(settings[p]));
            steady = ($urandom_range(0, 3) == 0);
            fill_phase(ITEMS_PER_PHASE, settings[p]);
            wait_drained();
        end

        $display("ran %0d requests over %0d list-count settings, zero and above the list count",
                 n_sent, n_settings);
        $display("%0d pushes stored, %0d dropped on a full list, %0d pops served, %0d empty pops",
                 n_pushed, n_dropped, n_popped, n_empty);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
